// ----- src/sector_stream_playhead_assert.svh -----
// ----------------------------------------------------------------------------
// sector_stream_playhead_assert.svh
// Assertion macros for the sector stream playhead. Each macro expects aclk
// and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef SECTOR_STREAM_PLAYHEAD_ASSERT_SVH
`define SECTOR_STREAM_PLAYHEAD_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SSP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("playhead assertion failed");

// next-cycle implication
`define SSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("playhead assertion failed");

`else

`define SSP_ASSERT_IMPLY(label, ante, cons)
`define SSP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssp_pkg
// Types and constants shared by the sector stream playhead modules.
// ----------------------------------------------------------------------------
package ssp_pkg;

    // frames per sector is a power of two: sector index is a shift
    localparam int unsigned FPS_SHIFT         = 10;
    localparam int unsigned SECTOR_FRAMES     = 1 << FPS_SHIFT;
    localparam int unsigned BLOCKS_PER_SECTOR = 8;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TOTAL_FRAMES   = 2'd0,
        CFG_SECTOR_TOTAL   = 2'd1,
        CFG_BLOCK_CAPACITY = 2'd2,
        CFG_LOOP_ENABLE    = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MODE_ADVANCE = 3'd0,
        MODE_READY   = 3'd1,
        MODE_PLAY    = 3'd2,
        MODE_STOP    = 3'd3,
        MODE_SEEK    = 3'd4,
        MODE_DIR     = 3'd5,
        MODE_HDR     = 3'd6,
        MODE_RESTART = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_STOPPED  = 3'd0,
        ST_PLAYING  = 3'd1,
        ST_UNDERRUN = 3'd2,
        ST_END      = 3'd3,
        ST_START    = 3'd4
    } tstate_t;

    typedef enum logic [2:0] {
        TK_OK       = 3'd0,
        TK_CROSSED  = 3'd1,
        TK_UNDERRUN = 3'd2,
        TK_LOOPED   = 3'd3,
        TK_ENDED    = 3'd4,
        TK_START    = 3'd5,
        TK_NONE     = 3'd6
    } tick_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] step_count;
        logic [31:0] sector_number;
        logic [31:0] target_frame;
        logic        go_backward;
        logic [31:0] hdr_sector;
        logic [31:0] hdr_first_frame;
        logic [31:0] hdr_frame_count;
    } in_item_t;

    typedef struct packed {
        tick_t       tick_code;
        logic        accepted;
        logic [31:0] needed_sector;
        tstate_t     play_state;
        logic [31:0] frame_position;
        logic [31:0] underrun_episodes;
        logic        config_ok;
    } out_item_t;

    // playhead state
    typedef struct packed {
        logic [31:0] position;
        logic [31:0] res_sector;
        logic        res_valid;
        tstate_t     tstate;
        logic        reverse;
        logic [31:0] underrun;
    } pstate_t;

    // configuration as seen by the step logic
    typedef struct packed {
        logic [31:0] total_frames;
        logic [31:0] sector_total;
        logic        loop_enable;
        logic        ok;
    } cfg_view_t;

    localparam pstate_t PSTATE_RESET = '{
        position:   32'd0,
        res_sector: 32'd0,
        res_valid:  1'b0,
        tstate:     ST_STOPPED,
        reverse:    1'b0,
        underrun:   32'd0
    };

endpackage

// ----- src/ssp_cfg_check.sv -----
// ----------------------------------------------------------------------------
// ssp_cfg_check
// Song configuration check: length, sector count and region capacity.
// ----------------------------------------------------------------------------
module ssp_cfg_check (
    input  logic [31:0] total_frames,
    input  logic [31:0] sector_total,
    input  logic [31:0] block_capacity,
    output logic        ok
);

    localparam int unsigned BPS_W = $clog2(ssp_pkg::BLOCKS_PER_SECTOR + 1);
    localparam int unsigned CAP_W = 32 + BPS_W;

    logic [32:0]      expect_sectors;
    logic [CAP_W-1:0] blocks_needed;

    // ceil(total_frames / SECTOR_FRAMES)
    assign expect_sectors = ({1'b0, total_frames} + 33'(ssp_pkg::SECTOR_FRAMES - 1))
                            >> ssp_pkg::FPS_SHIFT;
    assign blocks_needed  = CAP_W'(sector_total) * CAP_W'(ssp_pkg::BLOCKS_PER_SECTOR);

    assign ok = (total_frames != 32'd0) && (sector_total != 32'd0)
             && (expect_sectors == {1'b0, sector_total})
             && (blocks_needed <= CAP_W'(block_capacity));

endmodule

// ----- src/ssp_step.sv -----
// ----------------------------------------------------------------------------
// ssp_step
// Command decode: next playhead state and the result word for one command.
// ----------------------------------------------------------------------------
module ssp_step (
    input  ssp_pkg::in_item_t  item,
    input  ssp_pkg::pstate_t   cur,
    input  ssp_pkg::cfg_view_t cfg,
    output ssp_pkg::pstate_t   nxt,
    output ssp_pkg::out_item_t res
);

    localparam int unsigned S  = ssp_pkg::FPS_SHIFT;
    localparam int unsigned HW = 32 + S + 1;

    logic [31:0]   need;
    logic          running;
    logic          adv_go;
    logic          hit;
    logic [31:0]   pos_dec;
    logic [32:0]   pos_sum;
    logic          rev_under;
    logic          fwd_over;
    logic          cross_dec;
    logic          cross_inc;
    logic          seek_ok;
    logic [HW-1:0] hdr_first;
    logic [HW-1:0] hdr_last_cnt;
    logic [HW-1:0] hdr_exp_cnt;
    logic          hdr_is_last;
    logic          hdr_ok;
    ssp_pkg::tick_t tick;
    logic          acc;

    assign need      = cur.position >> S;
    assign running   = (cur.tstate == ssp_pkg::ST_PLAYING)
                    || (cur.tstate == ssp_pkg::ST_UNDERRUN);
    assign adv_go    = (item.step_count != 16'd0) && cfg.ok && running;
    assign hit       = cur.res_valid && (cur.res_sector == need);
    assign pos_dec   = cur.position - {16'd0, item.step_count};
    assign pos_sum   = {1'b0, cur.position} + {17'd0, item.step_count};
    assign rev_under = {16'd0, item.step_count} > cur.position;
    assign fwd_over  = pos_sum >= {1'b0, cfg.total_frames};
    assign cross_dec = (pos_dec >> S) != need;
    assign cross_inc = (pos_sum[31:0] >> S) != need;
    assign seek_ok   = cfg.ok && (item.target_frame < cfg.total_frames);

    // header: first frame and frame count checked at full width
    assign hdr_first    = {1'b0, item.sector_number, {S{1'b0}}};
    assign hdr_last_cnt = HW'(cfg.total_frames) - hdr_first;
    assign hdr_is_last  = ({1'b0, item.sector_number} + 33'd1) == {1'b0, cfg.sector_total};
    assign hdr_exp_cnt  = hdr_is_last ? hdr_last_cnt : HW'(ssp_pkg::SECTOR_FRAMES);
    assign hdr_ok = cfg.ok && (item.sector_number < cfg.sector_total)
                 && (item.hdr_sector == item.sector_number)
                 && (HW'(item.hdr_first_frame) == hdr_first)
                 && (HW'(item.hdr_frame_count) == hdr_exp_cnt);

    // next state
    always_comb begin
        nxt = cur;
        unique case (item.mode)
            ssp_pkg::MODE_ADVANCE: begin
                if (adv_go) begin
                    if (!hit) begin
                        if (cur.tstate != ssp_pkg::ST_UNDERRUN) begin
                            nxt.underrun = cur.underrun + 32'd1;
                        end
                        nxt.tstate = ssp_pkg::ST_UNDERRUN;
                    end else if (cur.reverse) begin
                        if (rev_under) begin
                            nxt.position = 32'd0;
                            nxt.tstate   = ssp_pkg::ST_START;
                        end else begin
                            nxt.position = pos_dec;
                            nxt.tstate   = ssp_pkg::ST_PLAYING;
                        end
                    end else if (fwd_over) begin
                        if (cfg.loop_enable) begin
                            nxt.position  = 32'd0;
                            nxt.res_valid = 1'b0;
                            nxt.tstate    = ssp_pkg::ST_PLAYING;
                        end else begin
                            nxt.position = cfg.total_frames;
                            nxt.tstate   = ssp_pkg::ST_END;
                        end
                    end else begin
                        nxt.position = pos_sum[31:0];
                        nxt.tstate   = ssp_pkg::ST_PLAYING;
                    end
                end
            end
            ssp_pkg::MODE_READY: begin
                nxt.res_sector = item.sector_number;
                nxt.res_valid  = 1'b1;
                if (cur.tstate == ssp_pkg::ST_UNDERRUN && item.sector_number == need) begin
                    nxt.tstate = ssp_pkg::ST_PLAYING;
                end
            end
            ssp_pkg::MODE_PLAY: begin
                if (cfg.ok && cur.tstate == ssp_pkg::ST_STOPPED) begin
                    nxt.tstate = ssp_pkg::ST_PLAYING;
                end
            end
            ssp_pkg::MODE_STOP: begin
                nxt.tstate = ssp_pkg::ST_STOPPED;
            end
            ssp_pkg::MODE_SEEK: begin
                if (seek_ok) begin
                    nxt.position  = item.target_frame;
                    nxt.res_valid = 1'b0;
                    if (cur.tstate != ssp_pkg::ST_STOPPED) begin
                        nxt.tstate = ssp_pkg::ST_PLAYING;
                    end
                end
            end
            ssp_pkg::MODE_DIR: begin
                if (item.go_backward != cur.reverse) begin
                    nxt.reverse = item.go_backward;
                    if (!item.go_backward && cur.tstate == ssp_pkg::ST_START) begin
                        nxt.tstate = ssp_pkg::ST_PLAYING;
                    end else if (item.go_backward && cur.tstate == ssp_pkg::ST_END
                                 && cfg.total_frames != 32'd0) begin
                        nxt.position  = cfg.total_frames - 32'd1;
                        nxt.res_valid = 1'b0;
                        nxt.tstate    = ssp_pkg::ST_PLAYING;
                    end
                end
            end
            ssp_pkg::MODE_HDR: begin
                nxt = cur;
            end
            ssp_pkg::MODE_RESTART: begin
                nxt = ssp_pkg::PSTATE_RESET;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

    // tick and accept flag
    always_comb begin
        tick = ssp_pkg::TK_NONE;
        acc  = 1'b0;
        unique case (item.mode)
            ssp_pkg::MODE_ADVANCE: begin
                if (!adv_go) begin
                    tick = ssp_pkg::TK_NONE;
                end else if (!hit) begin
                    tick = ssp_pkg::TK_UNDERRUN;
                end else if (cur.reverse) begin
                    if (rev_under) begin
                        tick = ssp_pkg::TK_START;
                    end else begin
                        tick = cross_dec ? ssp_pkg::TK_CROSSED : ssp_pkg::TK_OK;
                    end
                end else if (fwd_over) begin
                    tick = cfg.loop_enable ? ssp_pkg::TK_LOOPED : ssp_pkg::TK_ENDED;
                end else begin
                    tick = cross_inc ? ssp_pkg::TK_CROSSED : ssp_pkg::TK_OK;
                end
            end
            ssp_pkg::MODE_SEEK: acc = seek_ok;
            ssp_pkg::MODE_HDR:  acc = hdr_ok;
            default: begin
                tick = ssp_pkg::TK_NONE;
                acc  = 1'b0;
            end
        endcase
    end

    assign res.tick_code         = tick;
    assign res.accepted          = acc;
    assign res.needed_sector     = nxt.position >> S;
    assign res.play_state        = nxt.tstate;
    assign res.frame_position    = nxt.position;
    assign res.underrun_episodes = nxt.underrun;
    assign res.config_ok         = cfg.ok;

endmodule

// ----- src/sector_stream_playhead.sv -----
// ----------------------------------------------------------------------------
// sector_stream_playhead
// Frame playhead of a sector-buffered song, one command per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries command words (advance, sector ready, play, stop, seek,
//   direction, header check, restart); m_* returns one status word per
//   command: tick code, accept flag, needed sector, play state, frame
//   position, underrun episode count and the configuration check.
//   cfg_we/cfg_index/cfg_wdata write the song registers; write only while no
//   command is in flight. The check result is registered behind them.
//   Throughput: one word per cycle while m_ready is high. The command is
//   decoded in a single pass from the input register into the result
//   register; the playhead state updates in the same edge, so the next
//   command sees it right away.
//   Stall: a result held by m_ready low keeps its register; one more word
//   can sit in the input register, then s_ready drops until m_ready rises.
//   Reset (aresetn low, synchronous): registers, playhead state and both
//   valid flags clear; the playhead is stopped at frame 0, forward.
// ----------------------------------------------------------------------------
`include "sector_stream_playhead_assert.svh"

module sector_stream_playhead (
    input  logic                                aclk,
    input  logic                                aresetn,
    // command channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ssp_pkg::in_item_t                   s_data,
    // status channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output ssp_pkg::out_item_t                  m_data,
    // register write port
    input  logic                                cfg_we,
    input  logic [ssp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // song registers
    logic [31:0] total_frames_reg;
    logic [31:0] sector_total_reg;
    logic [31:0] block_capacity_reg;
    logic        loop_enable_reg;
    logic        cfg_ok_reg;
    logic        cfg_ok_next;

    // pipeline
    ssp_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    ssp_pkg::out_item_t out_reg;
    logic               out_valid_reg;

    // playhead state
    ssp_pkg::pstate_t   state_reg;
    ssp_pkg::pstate_t   state_next;

    ssp_pkg::cfg_view_t cfg_view;
    ssp_pkg::out_item_t step_res;
    logic               step_fire;
    logic               s_fire;

    // a decoded word moves on when the result slot is free or draining
    assign step_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;
    assign s_fire    = s_valid && s_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_frames_reg   <= 32'd0;
            sector_total_reg   <= 32'd0;
            block_capacity_reg <= 32'd0;
            loop_enable_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (ssp_pkg::cfg_idx_t'(cfg_index))
                ssp_pkg::CFG_TOTAL_FRAMES:   total_frames_reg   <= cfg_wdata;
                ssp_pkg::CFG_SECTOR_TOTAL:   sector_total_reg   <= cfg_wdata;
                ssp_pkg::CFG_BLOCK_CAPACITY: block_capacity_reg <= cfg_wdata;
                ssp_pkg::CFG_LOOP_ENABLE:    loop_enable_reg    <= cfg_wdata[0];
                default:                     loop_enable_reg    <= loop_enable_reg;
            endcase
        end
    end

    ssp_cfg_check u_cfg_check (
        .total_frames   (total_frames_reg),
        .sector_total   (sector_total_reg),
        .block_capacity (block_capacity_reg),
        .ok             (cfg_ok_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_ok_reg <= 1'b0;
        end else begin
            cfg_ok_reg <= cfg_ok_next;
        end
    end

    assign cfg_view.total_frames = total_frames_reg;
    assign cfg_view.sector_total = sector_total_reg;
    assign cfg_view.loop_enable  = loop_enable_reg;
    assign cfg_view.ok           = cfg_ok_reg;

    ssp_step u_step (
        .item (in_reg),
        .cur  (state_reg),
        .cfg  (cfg_view),
        .nxt  (state_next),
        .res  (step_res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_data;
        end
    end

    // playhead state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ssp_pkg::PSTATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (step_fire) begin
                state_reg <= state_next;
            end
            if (step_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            out_reg <= step_res;
        end
    end

    // underrun count moves only on an underrun tick or a restart
    `SSP_ASSERT_IMPLY(a_urun_only_on_tick, step_fire && (step_res.tick_code != ssp_pkg::TK_UNDERRUN) && (in_reg.mode != ssp_pkg::MODE_RESTART), state_next.underrun == state_reg.underrun)
    // start reached always parks on frame 0
    `SSP_ASSERT_IMPLY(a_start_parks, step_fire && (step_res.tick_code == ssp_pkg::TK_START), (state_next.position == 32'd0) && (state_next.tstate == ssp_pkg::ST_START))
    // a bad configuration never lets the head move by advance
    `SSP_ASSERT_IMPLY(a_bad_cfg_no_tick, m_valid && !m_data.config_ok, m_data.tick_code == ssp_pkg::TK_NONE)
    // a decoded word always lands in the result register
    `SSP_ASSERT_NEXT(a_result_follows, step_fire, out_valid_reg && (out_reg.frame_position == state_reg.position))

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sector_stream_playhead. A shadow playhead follows
// every accepted command word and predicts the status word it must return.
// Directed words cover the transport corners. Random traffic then runs over
// a string of song settings, valid and broken, with random idle gaps on both
// channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD    = 8;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SONG_SETTINGS = 10;
    localparam int unsigned WORDS_PER_SET = 190;

    // ------------------------------------------------------------------------
    // Shadow playhead: song registers, transport state and the queue of
    // status words still owed by the block.
    // ------------------------------------------------------------------------
    class playhead_mirror;
        logic [31:0]        total_frames;
        logic [31:0]        sector_total;
        logic [31:0]        block_capacity;
        logic               loop_en;
        logic [31:0]        pos;
        logic [31:0]        res_sector;
        logic               res_valid;
        ssp_pkg::tstate_t   tstate;
        logic               rev;
        logic [31:0]        urun;
        ssp_pkg::out_item_t status_due[$];
        int unsigned        words_checked;
        int unsigned        bad_words;
        int unsigned        tick_hits[7];
        int unsigned        accepts;

        function new();
            total_frames   = '0;
            sector_total   = '0;
            block_capacity = '0;
            loop_en        = 1'b0;
            clear_state();
        endfunction

        function void clear_state();
            pos        = '0;
            res_sector = '0;
            res_valid  = 1'b0;
            tstate     = ssp_pkg::ST_STOPPED;
            rev        = 1'b0;
            urun       = '0;
        endfunction

        function void set_reg(ssp_pkg::cfg_idx_t idx, logic [31:0] v);
            case (idx)
                ssp_pkg::CFG_TOTAL_FRAMES:   total_frames   = v;
                ssp_pkg::CFG_SECTOR_TOTAL:   sector_total   = v;
                ssp_pkg::CFG_BLOCK_CAPACITY: block_capacity = v;
                ssp_pkg::CFG_LOOP_ENABLE:    loop_en        = v[0];
            endcase
        endfunction

        function logic [31:0] sector_of(logic [31:0] f);
            return f / ssp_pkg::SECTOR_FRAMES;
        endfunction

        // length and capacity rules, all in 64 bits
        function bit cfg_good();
            logic [63:0] want;
            if (total_frames == 0 || sector_total == 0) return 1'b0;
            want = (64'(total_frames) + 64'(ssp_pkg::SECTOR_FRAMES) - 64'd1)
                   / 64'(ssp_pkg::SECTOR_FRAMES);
            if (64'(sector_total) != want) return 1'b0;
            return 64'(sector_total) * 64'(ssp_pkg::BLOCKS_PER_SECTOR)
                   <= 64'(block_capacity);
        endfunction

        function bit header_good(ssp_pkg::in_item_t w);
            logic [31:0] idx;
            logic [63:0] first;
            logic [63:0] cnt;
            idx = w.sector_number;
            if (!cfg_good() || idx >= sector_total || w.hdr_sector != idx) return 1'b0;
            first = 64'(idx) * 64'(ssp_pkg::SECTOR_FRAMES);
            if (64'(w.hdr_first_frame) != first) return 1'b0;
            if (64'(idx) + 64'd1 == 64'(sector_total))
                cnt = 64'(total_frames) - first;
            else
                cnt = 64'(ssp_pkg::SECTOR_FRAMES);
            return 64'(w.hdr_frame_count) == cnt;
        endfunction

        function ssp_pkg::tick_t advance(logic [15:0] n);
            logic [31:0] need;
            logic [32:0] sum;
            if (n == 0 || !cfg_good()) return ssp_pkg::TK_NONE;
            if (tstate != ssp_pkg::ST_PLAYING && tstate != ssp_pkg::ST_UNDERRUN)
                return ssp_pkg::TK_NONE;
            need = sector_of(pos);
            if (!res_valid || res_sector != need) begin
                // only the entry into underrun counts as an episode
                if (tstate != ssp_pkg::ST_UNDERRUN) urun = urun + 32'd1;
                tstate = ssp_pkg::ST_UNDERRUN;
                return ssp_pkg::TK_UNDERRUN;
            end
            tstate = ssp_pkg::ST_PLAYING;
            if (rev) begin
                if (32'(n) > pos) begin
                    pos    = '0;
                    tstate = ssp_pkg::ST_START;
                    return ssp_pkg::TK_START;
                end
                pos = pos - 32'(n);
                return (sector_of(pos) != need) ? ssp_pkg::TK_CROSSED : ssp_pkg::TK_OK;
            end
            sum = {1'b0, pos} + {17'd0, n};
            if (sum >= {1'b0, total_frames}) begin
                if (loop_en) begin
                    pos       = '0;
                    res_valid = 1'b0;
                    return ssp_pkg::TK_LOOPED;
                end
                pos    = total_frames;
                tstate = ssp_pkg::ST_END;
                return ssp_pkg::TK_ENDED;
            end
            pos = sum[31:0];
            return (sector_of(pos) != need) ? ssp_pkg::TK_CROSSED : ssp_pkg::TK_OK;
        endfunction

        function void turn(logic back);
            if (rev == back) return;
            rev = back;
            if (!back && tstate == ssp_pkg::ST_START) begin
                tstate = ssp_pkg::ST_PLAYING;
                return;
            end
            if (back && tstate == ssp_pkg::ST_END && total_frames != 0) begin
                pos       = total_frames - 32'd1;
                res_valid = 1'b0;
                tstate    = ssp_pkg::ST_PLAYING;
            end
        endfunction

        // one accepted command word -> one status word owed
        function void take_command(ssp_pkg::in_item_t w);
            ssp_pkg::out_item_t e;
            ssp_pkg::tick_t     t;
            logic               acc;
            t   = ssp_pkg::TK_NONE;
            acc = 1'b0;
            case (w.mode)
                ssp_pkg::MODE_ADVANCE: t = advance(w.step_count);
                ssp_pkg::MODE_READY: begin
                    res_sector = w.sector_number;
                    res_valid  = 1'b1;
                    if (tstate == ssp_pkg::ST_UNDERRUN && w.sector_number == sector_of(pos))
                        tstate = ssp_pkg::ST_PLAYING;
                end
                ssp_pkg::MODE_PLAY: begin
                    if (cfg_good() && tstate == ssp_pkg::ST_STOPPED)
                        tstate = ssp_pkg::ST_PLAYING;
                end
                ssp_pkg::MODE_STOP: tstate = ssp_pkg::ST_STOPPED;
                ssp_pkg::MODE_SEEK: begin
                    if (cfg_good() && w.target_frame < total_frames) begin
                        pos       = w.target_frame;
                        res_valid = 1'b0;
                        if (tstate != ssp_pkg::ST_STOPPED) tstate = ssp_pkg::ST_PLAYING;
                        acc = 1'b1;
                    end
                end
                ssp_pkg::MODE_DIR:     turn(w.go_backward);
                ssp_pkg::MODE_HDR:     acc = header_good(w);
                ssp_pkg::MODE_RESTART: clear_state();
            endcase
            e.tick_code         = t;
            e.accepted          = acc;
            e.needed_sector     = sector_of(pos);
            e.play_state        = tstate;
            e.frame_position    = pos;
            e.underrun_episodes = urun;
            e.config_ok         = cfg_good();
            status_due.push_back(e);
        endfunction

        function string describe(ssp_pkg::out_item_t o);
            return $sformatf("tick %0d acc %0d sector %0h state %0d frame %0h urun %0d cfg %0d",
                             o.tick_code, o.accepted, o.needed_sector, o.play_state,
                             o.frame_position, o.underrun_episodes, o.config_ok);
        endfunction

        function void match_status(ssp_pkg::out_item_t got);
            ssp_pkg::out_item_t e;
            bit                 bad;
            if (status_due.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("status word with nothing outstanding: %s", describe(got));
                return;
            end
            e = status_due.pop_front();
            words_checked++;
            tick_hits[e.tick_code]++;
            if (e.accepted) accepts++;
            bad = (got.tick_code !== e.tick_code) || (got.accepted !== e.accepted) ||
                  (got.needed_sector !== e.needed_sector) ||
                  (got.play_state !== e.play_state) ||
                  (got.frame_position !== e.frame_position) ||
                  (got.underrun_episodes !== e.underrun_episodes) ||
                  (got.config_ok !== e.config_ok);
            if (bad) begin
                bad_words++;
                if (bad_words <= 10) begin
                    $display("status word %0d differs", words_checked);
                    $display("  exp %s", describe(e));
                    $display("  got %s", describe(got));
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    ssp_pkg::in_item_t  s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    ssp_pkg::out_item_t m_data;
    logic               cfg_we    = 1'b0;
    logic [ssp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    playhead_mirror mirror;
    bit             calm         = 1'b0;   // no idling on either side
    int unsigned    sent         = 0;
    int unsigned    settings     = 0;
    int unsigned    bad_settings = 0;
    int unsigned    cycle_count  = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    sector_stream_playhead dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Gap lengths: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Result side: random stalls on m_ready, one assignment per edge.
    initial begin
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    // Status words are checked on the edge that takes them. The inputs are
    // driven by NBA at the edge, so everything sampled here is pre-edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) mirror.match_status(m_data);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("watchdog: %0d cycles, %0d status words still owed",
                     cycle_count, mirror.status_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Every field random; the caller overrides what the command uses, so the
    // unused fields keep toggling.
    function automatic ssp_pkg::in_item_t random_word(ssp_pkg::mode_t m);
        ssp_pkg::in_item_t w;
        w.mode            = m;
        w.step_count      = 16'($urandom);
        w.sector_number   = $urandom;
        w.target_frame    = $urandom;
        w.go_backward     = 1'($urandom);
        w.hdr_sector      = $urandom;
        w.hdr_first_frame = $urandom;
        w.hdr_frame_count = $urandom;
        return w;
    endfunction

    // Valid only drops when a gap follows, so back-to-back words keep it
    // high with a single NBA per edge.
    task automatic send_word(ssp_pkg::in_item_t w);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        mirror.take_command(w);
        sent++;
    endtask

    task automatic cmd(ssp_pkg::mode_t m);
        send_word(random_word(m));
    endtask

    task automatic advance_by(logic [15:0] n);
        ssp_pkg::in_item_t w;
        w = random_word(ssp_pkg::MODE_ADVANCE);
        w.step_count = n;
        send_word(w);
    endtask

    task automatic mark_ready(logic [31:0] sec);
        ssp_pkg::in_item_t w;
        w = random_word(ssp_pkg::MODE_READY);
        w.sector_number = sec;
        send_word(w);
    endtask

    task automatic seek_to(logic [31:0] f);
        ssp_pkg::in_item_t w;
        w = random_word(ssp_pkg::MODE_SEEK);
        w.target_frame = f;
        send_word(w);
    endtask

    task automatic set_reverse(logic back);
        ssp_pkg::in_item_t w;
        w = random_word(ssp_pkg::MODE_DIR);
        w.go_backward = back;
        send_word(w);
    endtask

    task automatic check_header(logic [31:0] idx, logic [31:0] hs, logic [31:0] hf,
                                logic [31:0] hc);
        ssp_pkg::in_item_t w;
        w = random_word(ssp_pkg::MODE_HDR);
        w.sector_number   = idx;
        w.hdr_sector      = hs;
        w.hdr_first_frame = hf;
        w.hdr_frame_count = hc;
        send_word(w);
    endtask

    // Song registers change only with the block drained: every owed status
    // word back first. The check is registered, so the task waits for it
    // before the next command.
    task automatic program_song(logic [31:0] frames, logic [31:0] sectors,
                                logic [31:0] blocks, logic [31:0] loop_word);
        ssp_pkg::cfg_idx_t order[4];
        logic [31:0]       vals[4];
        order = '{ssp_pkg::CFG_TOTAL_FRAMES, ssp_pkg::CFG_SECTOR_TOTAL,
                  ssp_pkg::CFG_BLOCK_CAPACITY, ssp_pkg::CFG_LOOP_ENABLE};
        vals  = '{frames, sectors, blocks, loop_word};
        s_valid <= 1'b0;
        while (mirror.status_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            mirror.set_reg(order[i], vals[i]);
        end
        cfg_we <= 1'b0;
        repeat (2) @(posedge aclk);
        settings++;
        if (!mirror.cfg_good()) bad_settings++;
    endtask

    function automatic logic [31:0] sectors_for(logic [31:0] frames);
        return 32'((64'(frames) + 64'(ssp_pkg::SECTOR_FRAMES) - 64'd1)
                   / 64'(ssp_pkg::SECTOR_FRAMES));
    endfunction

    // Random command, steered by the shadow state: most sector-ready words
    // name the sector under the head and most headers are built from the song
    // settings, so playback gets past underrun and reaches the song edges.
    function automatic ssp_pkg::in_item_t next_command();
        ssp_pkg::in_item_t w;
        int unsigned       r;
        int unsigned       q;
        logic [31:0]       need;
        logic [31:0]       idx;
        logic [31:0]       tf;
        logic [31:0]       st;
        tf   = mirror.total_frames;
        st   = mirror.sector_total;
        need = mirror.pos / ssp_pkg::SECTOR_FRAMES;
        r    = $urandom_range(0, 99);
        q    = $urandom_range(0, 19);
        if (r < 38) begin
            w = random_word(ssp_pkg::MODE_ADVANCE);
            if (q == 0) w.step_count = 16'd0;
            else if (q == 1) w.step_count = 16'hFFFF;
            else if (q >= 4) w.step_count = 16'($urandom_range(1, 1500));
        end else if (r < 62) begin
            w = random_word(ssp_pkg::MODE_READY);
            if (q < 16) w.sector_number = need;
            else if (q < 18) w.sector_number = need + 32'd1;
        end else if (r < 70) begin
            w = random_word(ssp_pkg::MODE_PLAY);
        end else if (r < 73) begin
            w = random_word(ssp_pkg::MODE_STOP);
        end else if (r < 80) begin
            w = random_word(ssp_pkg::MODE_SEEK);
            if (q < 12 && tf != 0) w.target_frame = $urandom % tf;
            else if (q < 15) w.target_frame = tf - 32'd1 - $urandom_range(0, 3000);
            else if (q < 17) w.target_frame = tf;
        end else if (r < 88) begin
            w = random_word(ssp_pkg::MODE_DIR);
        end else if (r < 97) begin
            w = random_word(ssp_pkg::MODE_HDR);
            if (q < 14) begin
                if (q < 4 || st == 0) idx = st - 32'd1;
                else idx = $urandom % st;
                w.sector_number   = idx;
                w.hdr_sector      = idx;
                w.hdr_first_frame = idx * ssp_pkg::SECTOR_FRAMES;
                if (idx + 32'd1 == st)
                    w.hdr_frame_count = tf - idx * ssp_pkg::SECTOR_FRAMES;
                else
                    w.hdr_frame_count = ssp_pkg::SECTOR_FRAMES;
                // flip one bit of one field now and then
                case ($urandom_range(0, 5))
                    0: w.hdr_sector      ^= 32'd1 << $urandom_range(0, 31);
                    1: w.hdr_first_frame ^= 32'd1 << $urandom_range(0, 31);
                    2: w.hdr_frame_count ^= 32'd1 << $urandom_range(0, 31);
                    default: ;
                endcase
            end
        end else begin
            w = random_word(ssp_pkg::MODE_RESTART);
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] tf;
        logic [31:0] st;
        logic [31:0] bc;
        logic [31:0] lw;
        int unsigned kind;

        mirror = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Capacity one block short: advance, play and seek refused, header
        // rejected; ready, direction, stop and restart still act.
        program_song(32'd5000, 32'd5, 32'd39, 32'd0);
        cmd(ssp_pkg::MODE_PLAY);
        advance_by(16'd10);
        seek_to(32'd0);
        check_header(32'd0, 32'd0, 32'd0, 32'd1024);
        mark_ready(32'd0);
        set_reverse(1'b1);
        cmd(ssp_pkg::MODE_STOP);
        cmd(ssp_pkg::MODE_RESTART);

        // Valid song, capacity exactly enough.
        program_song(32'd5000, 32'd5, 32'd40, 32'd0);
        cmd(ssp_pkg::MODE_PLAY);
        advance_by(16'd100);                 // nothing ready: underrun
        advance_by(16'd100);                 // still underrun, no new episode
        mark_ready(32'd0);                   // right sector: playing again
        advance_by(16'd0);                   // zero count: no tick
        advance_by(16'd1000);
        advance_by(16'd100);                 // crosses into sector 1
        seek_to(32'd4999);                   // last frame
        mark_ready(32'd4);
        advance_by(16'hFFFF);                // runs off the end, no loop
        check_header(32'd4, 32'd4, 32'd4096, 32'd904);  // short last sector
        check_header(32'd5, 32'd5, 32'd5120, 32'd1024); // past the song

        // Parked at the end with zero length: reversing flips only direction.
        program_song(32'd0, 32'd5, 32'd40, 32'd0);
        set_reverse(1'b1);
        advance_by(16'd1);

        // Reverse from the end, run back into frame 0, then forward again.
        program_song(32'd5000, 32'd5, 32'd40, 32'd0);
        set_reverse(1'b0);
        set_reverse(1'b1);
        mark_ready(32'd4);
        advance_by(16'hFFFF);
        set_reverse(1'b0);

        // Largest song: forward sum must not wrap at 32 bits.
        program_song(32'hFFFF_FFFF, 32'h0040_0000, 32'hFFFF_FFFF, 32'd0);
        seek_to(32'hFFFF_FFFE);
        mark_ready(32'h003F_FFFF);
        advance_by(16'hFFFF);

        // Random traffic over a run of song settings. State carries across
        // settings, so a head beyond a shorter new song gets exercised too.
        for (int p = 0; p < SONG_SETTINGS; p++) begin
            kind = $urandom_range(0, 9);
            lw   = $urandom;
            if (kind == 4) tf = $urandom_range(1, 1100);
            else if (kind == 5) tf = 32'hFFFF_FFFF - $urandom_range(0, 5000);
            else if (kind == 6) tf = $urandom;
            else tf = $urandom_range(1, 20000);
            st = sectors_for(tf);
            bc = ($urandom_range(0, 1) == 0)
                 ? st * ssp_pkg::BLOCKS_PER_SECTOR
                 : st * ssp_pkg::BLOCKS_PER_SECTOR + $urandom_range(1, 100);
            if (kind == 5 && $urandom_range(0, 1) == 0) bc = 32'hFFFF_FFFF;
            if (kind == 7) lw[0] = 1'b1;
            if (kind >= 8) begin
                // broken settings
                case ($urandom_range(0, 5))
                    0: st = st + 32'd1;
                    1: st = st - 32'd1;
                    2: bc = st * ssp_pkg::BLOCKS_PER_SECTOR - 32'd1;
                    3: tf = 32'd0;
                    4: begin
                        st = 32'hFFFF_FFFF;
                        bc = 32'hFFFF_FFFF;
                    end
                    default: begin
                        st = $urandom;
                        bc = $urandom;
                    end
                endcase
            end
            program_song(tf, st, bc, lw);
            calm = (p % 4 == 3);
            repeat (WORDS_PER_SET) send_word(next_command());
            calm = 1'b0;
        end

        // Drain, then let the pipeline idle so any stray word would show.
        s_valid <= 1'b0;
        while (mirror.status_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d commands over %0d song settings (%0d failing the song checks)",
                 sent, settings, bad_settings);
        $display("ticks ok %0d cross %0d urun %0d loop %0d end %0d start %0d none %0d, acc %0d",
                 mirror.tick_hits[ssp_pkg::TK_OK], mirror.tick_hits[ssp_pkg::TK_CROSSED],
                 mirror.tick_hits[ssp_pkg::TK_UNDERRUN], mirror.tick_hits[ssp_pkg::TK_LOOPED],
                 mirror.tick_hits[ssp_pkg::TK_ENDED], mirror.tick_hits[ssp_pkg::TK_START],
                 mirror.tick_hits[ssp_pkg::TK_NONE], mirror.accepts);
        if (mirror.bad_words == 0 && mirror.status_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
